// File: rtl/core/sia_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sia_pkg: shared types for the session id allocator
// Request, result and internal command beats, status and state codes.
// ----------------------------------------------------------------------------
package sia_pkg;

    localparam int SID_W = 10;
    localparam int W32   = 32;

    typedef enum logic [1:0] {
        K_OPEN    = 2'd0,
        K_CLAIM   = 2'd1,
        K_RELEASE = 2'd2,
        K_UNKNOWN = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        STS_OK         = 3'd0,
        STS_MISMATCH   = 3'd1,
        STS_NO_FREE    = 3'd2,
        STS_BAD_ID     = 3'd3,
        STS_NOT_IN_USE = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        OP_OPEN    = 2'd0,
        OP_CLAIM   = 2'd1,
        OP_RELEASE = 2'd2,
        OP_BAD     = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EXEC  = 2'd2
    } t_bstate;

    typedef struct packed {
        t_kind              kind;
        logic [SID_W-1:0]   sid;
        logic [W32-1:0]     magic;
        logic [W32-1:0]     data_handle;
        logic [W32-1:0]     reply_handle;
        logic [W32-1:0]     now_seconds;
    } t_req;

    typedef struct packed {
        t_status            status;
        logic [SID_W-1:0]   out_sid;
        logic [W32-1:0]     out_data;
        logic [W32-1:0]     out_reply;
        logic [W32-1:0]     out_start;
    } t_res;

    typedef struct packed {
        t_op                op;
        logic [SID_W-1:0]   sid;
        logic [W32-1:0]     magic;
        logic [W32-1:0]     data;
        logic [W32-1:0]     reply;
        logic [W32-1:0]     start;
    } t_cmd;

    // session table payload beside the magic tag
    typedef struct packed {
        logic [W32-1:0]     data;
        logic [W32-1:0]     reply;
        logic [W32-1:0]     start;
    } t_entry;

    // back end status toward the front end
    typedef struct packed {
        logic               take;
        logic               clearing;
    } t_bk_stat;

endpackage
`default_nettype wire

// File: rtl/core/sia_q.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sia_q: two-entry queue
// Small register queue that decouples a producer from a consumer.
// ----------------------------------------------------------------------------
module sia_q #(
    parameter int W = 8
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_wr,
    input  wire logic [W-1:0] i_wdata,
    input  wire logic         i_rd,
    output logic              o_empty,
    output logic              o_full,
    output logic [W-1:0]      o_rdata
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    logic         wr_en;
    logic         rd_en;

    assign o_empty = (r_cnt == 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign wr_en   = i_wr && !o_full;
    assign rd_en   = i_rd && !o_empty;
    assign o_rdata = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (wr_en) begin
                r_wp <= ~r_wp;
            end
            if (rd_en) begin
                r_rp <= ~r_rp;
            end
            case ({wr_en, rd_en})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wp] <= i_wdata;
        end
    end

endmodule
`default_nettype wire

// File: rtl/core/sia_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sia_front: request intake and classification
// Accept request beats, range-check the id, queue commands for the back end.
// ----------------------------------------------------------------------------
module sia_front
    import sia_pkg::*;
#(
    parameter int TABLE_SIZE = 1024
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_push,
    input  wire t_req     i_req,
    output logic          o_full,
    input  wire t_bk_stat i_bk,
    output logic          o_cmd_vld,
    output t_cmd          o_cmd
);

    localparam int CMD_W = $bits(t_cmd);

    t_cmd             cmd;
    logic             sid_ok;
    logic             q_full;
    logic             q_empty;
    logic [CMD_W-1:0] q_rdata;

    assign sid_ok = (32'(i_req.sid) < 32'(TABLE_SIZE));

    always_comb begin
        cmd.sid   = i_req.sid;
        cmd.magic = i_req.magic;
        cmd.data  = i_req.data_handle;
        cmd.reply = i_req.reply_handle;
        cmd.start = i_req.now_seconds;
        unique case (i_req.kind)
            K_OPEN:    cmd.op = OP_OPEN;
            K_CLAIM:   cmd.op = sid_ok ? OP_CLAIM : OP_BAD;
            K_RELEASE: cmd.op = sid_ok ? OP_RELEASE : OP_BAD;
            K_UNKNOWN: cmd.op = OP_BAD;
        endcase
    end

    // hold intake while the back end sweeps the table
    assign o_full = q_full || i_bk.clearing;

    sia_q #(
        .W (CMD_W)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_push && !o_full),
        .i_wdata (cmd),
        .i_rd    (i_bk.take),
        .o_empty (q_empty),
        .o_full  (q_full),
        .o_rdata (q_rdata)
    );

    assign o_cmd_vld = !q_empty;
    assign o_cmd     = t_cmd'(q_rdata);

endmodule
`default_nettype wire

// File: rtl/core/sia_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sia_back: session table and free list execution
// Read the table when a command is taken, update it and queue the result in the next cycle.
// ----------------------------------------------------------------------------
module sia_back
    import sia_pkg::*;
#(
    parameter int TABLE_SIZE = 1024,
    parameter int BATCH      = 10
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_cmd_vld,
    input  wire t_cmd i_cmd,
    output t_bk_stat  o_stat,
    input  wire logic i_pop,
    output logic      o_empty,
    output t_res      o_res
);

    localparam int IW    = $clog2(TABLE_SIZE);
    localparam int CW    = IW + 1;
    localparam int LW    = $clog2(BATCH + 1);
    localparam int RES_W = $bits(t_res);
    localparam logic [CW-1:0] TS_C = CW'(TABLE_SIZE);
    localparam logic [IW-1:0] LAST = IW'(TABLE_SIZE - 1);

    // table and free list storage
    logic [W32-1:0] m_magic [TABLE_SIZE];
    t_entry         m_pay   [TABLE_SIZE];
    logic           m_used  [TABLE_SIZE];
    logic [IW-1:0]  m_free  [TABLE_SIZE];

    t_bstate        r_state;
    t_bstate        n_state;
    t_cmd           r_cmd;
    logic [IW-1:0]  r_clr;
    logic [IW-1:0]  r_head;
    logic [IW-1:0]  n_head;
    logic [IW-1:0]  r_tail;
    logic [IW-1:0]  n_tail;
    logic [CW-1:0]  r_cnt;
    logic [CW-1:0]  n_cnt;
    logic [CW-1:0]  r_hw;
    logic [CW-1:0]  n_hw;
    logic [LW-1:0]  r_lazy;
    logic [LW-1:0]  n_lazy;

    logic [W32-1:0] r_rd_magic;
    t_entry         r_rd_pay;
    logic           r_rd_used;
    logic [IW-1:0]  r_rd_free;

    logic           take;
    logic           exec;
    logic           rq_full;
    logic [RES_W-1:0] rq_rdata;
    t_res           res;

    logic [IW-1:0]  rd_addr;
    logic [IW-1:0]  tw_addr;
    logic           mg_we;
    logic [W32-1:0] mg_data;
    logic           pay_we;
    t_entry         pay_data;
    logic           us_we;
    logic           us_data;
    logic           fw_we;
    logic [IW-1:0]  fw_data;
    logic [CW-1:0]  rem;
    logic [LW-1:0]  refill_left;

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] p);
        return (p == LAST) ? '0 : p + IW'(1);
    endfunction

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (r_clr == LAST) n_state = S_IDLE;
            S_IDLE:  if (take) n_state = S_EXEC;
            S_EXEC:  n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    // state outputs
    always_comb begin
        take            = 1'b0;
        exec            = 1'b0;
        o_stat.clearing = 1'b0;
        unique case (r_state)
            S_CLEAR: o_stat.clearing = 1'b1;
            S_IDLE:  take = i_cmd_vld && !rq_full;
            S_EXEC:  exec = 1'b1;
            default: o_stat.clearing = 1'b0;
        endcase
        o_stat.take = take;
    end

    assign rd_addr = IW'(i_cmd.sid);

    // ids left in a fresh batch after the first one is handed out
    always_comb begin
        rem = TS_C - r_hw;
        if (32'(rem) >= 32'(BATCH)) begin
            refill_left = LW'(BATCH - 1);
        end else begin
            refill_left = LW'(rem - CW'(1));
        end
    end

    // sweep the table after reset, or execute the held command
    always_comb begin
        n_head   = r_head;
        n_tail   = r_tail;
        n_cnt    = r_cnt;
        n_hw     = r_hw;
        n_lazy   = r_lazy;
        tw_addr  = IW'(r_cmd.sid);
        mg_we    = 1'b0;
        mg_data  = r_cmd.magic;
        pay_we   = 1'b0;
        pay_data = '{data: r_cmd.data, reply: r_cmd.reply, start: r_cmd.start};
        us_we    = 1'b0;
        us_data  = 1'b0;
        fw_we    = 1'b0;
        fw_data  = IW'(r_cmd.sid);
        res           = '0;
        res.status    = STS_OK;
        res.out_sid   = r_cmd.sid;

        if (r_state == S_CLEAR) begin
            tw_addr  = r_clr;
            mg_we    = 1'b1;
            mg_data  = '0;
            pay_we   = 1'b1;
            pay_data = '0;
            us_we    = 1'b1;
        end else if (exec) begin
            unique case (r_cmd.op)
                OP_OPEN: begin
                    us_data = 1'b1;
                    if (r_lazy != '0) begin
                        tw_addr = IW'(r_hw);
                        n_hw    = r_hw + CW'(1);
                        n_lazy  = r_lazy - LW'(1);
                    end else if (r_cnt != '0) begin
                        tw_addr = r_rd_free;
                        n_head  = wrap_inc(r_head);
                        n_cnt   = r_cnt - CW'(1);
                    end else if (r_hw != TS_C) begin
                        tw_addr = IW'(r_hw);
                        n_hw    = r_hw + CW'(1);
                        n_lazy  = refill_left;
                    end else begin
                        res.status = STS_NO_FREE;
                    end
                    if (res.status == STS_OK) begin
                        mg_we       = 1'b1;
                        pay_we      = 1'b1;
                        us_we       = 1'b1;
                        res.out_sid = SID_W'(tw_addr);
                    end else begin
                        res.out_sid = '0;
                    end
                end
                OP_CLAIM: begin
                    if (r_rd_magic == r_cmd.magic) begin
                        mg_we         = 1'b1;
                        mg_data       = '0;
                        res.out_data  = r_rd_pay.data;
                        res.out_reply = r_rd_pay.reply;
                        res.out_start = r_rd_pay.start;
                    end else begin
                        res.status = STS_MISMATCH;
                    end
                end
                OP_RELEASE: begin
                    if (r_rd_used) begin
                        us_we  = 1'b1;
                        fw_we  = 1'b1;
                        n_tail = wrap_inc(r_tail);
                        n_cnt  = r_cnt + CW'(1);
                    end else begin
                        res.status = STS_NOT_IN_USE;
                    end
                end
                OP_BAD: res.status = STS_BAD_ID;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_head  <= '0;
            r_tail  <= '0;
            r_cnt   <= '0;
            r_hw    <= '0;
            r_lazy  <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == S_CLEAR) begin
                r_clr <= r_clr + IW'(1);
            end
            if (exec) begin
                r_head <= n_head;
                r_tail <= n_tail;
                r_cnt  <= n_cnt;
                r_hw   <= n_hw;
                r_lazy <= n_lazy;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_cmd <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mg_we) begin
            m_magic[tw_addr] <= mg_data;
        end
        if (take) begin
            r_rd_magic <= m_magic[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (pay_we) begin
            m_pay[tw_addr] <= pay_data;
        end
        if (take) begin
            r_rd_pay <= m_pay[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (us_we) begin
            m_used[tw_addr] <= us_data;
        end
        if (take) begin
            r_rd_used <= m_used[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (fw_we) begin
            m_free[r_tail] <= fw_data;
        end
        if (take) begin
            r_rd_free <= m_free[r_head];
        end
    end

    sia_q #(
        .W (RES_W)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (exec),
        .i_wdata (res),
        .i_rd    (i_pop),
        .o_empty (o_empty),
        .o_full  (rq_full),
        .o_rdata (rq_rdata)
    );

    assign o_res = t_res'(rq_rdata);

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= TS_C)
        else $error("free list count exceeds table size");

    a_hw_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_hw <= TS_C)
        else $error("high-water mark exceeds table size");

    a_lazy_ids: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_lazy != '0) |-> (r_hw != TS_C))
        else $error("pending batch ids with no ids left");

    a_clear_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_CLEAR) |=> (r_state != S_CLEAR))
        else $error("table sweep restarted outside reset");

endmodule
`default_nettype wire

// File: rtl/core/session_id_allocator_with_tag_check.sv
`default_nettype none
// ----------------------------------------------------------------------------
// session_id_allocator_with_tag_check: session id allocator with tag check
// Hands out session ids from a free list, keeps a tagged session table.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel: drive i_req and raise push; a beat is taken on a clock
//    edge with push high and full low. kind selects open, claim or release.
//  - Result channel: while empty is low, o_res holds the oldest result; raise
//    pop to take it. Every request beat yields exactly one result beat.
//  - Path: a taken request waits in the front-end queue; the back end takes
//    it with its table read and queues its result from the execute state.
//  - Back end: takes no new request before the last is done. It reads the
//    session table when it takes a request, writes it and the free list in
//    the next cycle, and each table memory has one read and one write port.
//  - Reset: synchronous, active low. After reset the back end sweeps the
//    session table to zero, one entry per cycle, over all TABLE_SIZE entries;
//    full stays high during the sweep.
//  - Stall: if pop is held off, the back end parks results in a two-beat
//    queue and then stops; the front end buffers two more request beats
//    and then raises full.
// ----------------------------------------------------------------------------
module session_id_allocator_with_tag_check
    import sia_pkg::*;
#(
    parameter int TABLE_SIZE = 1024,
    parameter int BATCH      = 10
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic push,
    output logic      full,
    input  wire t_req i_req,
    input  wire logic pop,
    output logic      empty,
    output t_res      o_res
);

    t_bk_stat bk_stat;
    logic     cmd_vld;
    t_cmd     cmd;

    // front end: take request beats and classify them
    sia_front #(
        .TABLE_SIZE (TABLE_SIZE)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_req     (i_req),
        .o_full    (full),
        .i_bk      (bk_stat),
        .o_cmd_vld (cmd_vld),
        .o_cmd     (cmd)
    );

    // back end: run commands against the table and free list
    sia_back #(
        .TABLE_SIZE (TABLE_SIZE),
        .BATCH      (BATCH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (cmd_vld),
        .i_cmd     (cmd),
        .o_stat    (bk_stat),
        .i_pop     (pop),
        .o_empty   (empty),
        .o_res     (o_res)
    );

endmodule
`default_nettype wire

// File: test/session_id_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// session_id_checker: result checker for the session id allocator
// Watches the request and result channels, keeps its own copy of the free
// list and session table, and compares every result beat with the outcome
// worked out for the request beat that caused it.
// ----------------------------------------------------------------------------
module session_id_checker
    import sia_pkg::*;
#(
    parameter int TABLE_SIZE = 1024,
    parameter int BATCH      = 10
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire logic i_full,
    input  t_req      i_req,
    input  wire logic i_pop,
    input  wire logic i_empty,
    input  t_res      i_res,
    output int        o_errors,
    output int        o_pending
);

    // shadow of the allocator state
    logic [SID_W-1:0] free_ids  [TABLE_SIZE];
    int               fl_head;
    int               fl_tail;
    int               fl_count;
    int               next_fresh;
    bit               busy      [TABLE_SIZE];
    logic [W32-1:0]   tag_mem   [TABLE_SIZE];
    logic [W32-1:0]   data_mem  [TABLE_SIZE];
    logic [W32-1:0]   reply_mem [TABLE_SIZE];
    logic [W32-1:0]   start_mem [TABLE_SIZE];

    t_res pending_results [$];
    int   mismatch_count = 0;

    assign o_errors = mismatch_count;

    task automatic flag_mismatch(input string msg);
        $display("ERROR @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function automatic void clear_state();
        fl_head    = 0;
        fl_tail    = 0;
        fl_count   = 0;
        next_fresh = 0;
        for (int i = 0; i < TABLE_SIZE; i++) begin
            free_ids[i]  = '0;
            busy[i]      = 1'b0;
            tag_mem[i]   = '0;
            data_mem[i]  = '0;
            reply_mem[i] = '0;
            start_mem[i] = '0;
        end
    endfunction

    function automatic void free_push(input int id);
        if (fl_count < TABLE_SIZE) begin
            free_ids[fl_tail] = SID_W'(id);
            fl_tail = (fl_tail + 1 >= TABLE_SIZE) ? 0 : fl_tail + 1;
            fl_count++;
        end
    endfunction

    // work out the result of one request and advance the shadow state
    function automatic t_res session_outcome(input t_req r);
        t_res res;
        int   id;
        res         = '0;
        res.status  = STS_OK;
        res.out_sid = r.sid;
        case (r.kind)
            K_OPEN: begin
                if (fl_count == 0) begin
                    for (int n = 0; n < BATCH && next_fresh < TABLE_SIZE; n++) begin
                        free_push(next_fresh);
                        next_fresh++;
                    end
                end
                if (fl_count == 0) begin
                    res.status  = STS_NO_FREE;
                    res.out_sid = '0;
                end else begin
                    id = int'(free_ids[fl_head]);
                    fl_head = (fl_head + 1 >= TABLE_SIZE) ? 0 : fl_head + 1;
                    fl_count--;
                    busy[id]      = 1'b1;
                    tag_mem[id]   = r.magic;
                    data_mem[id]  = r.data_handle;
                    reply_mem[id] = r.reply_handle;
                    start_mem[id] = r.now_seconds;
                    res.out_sid   = SID_W'(id);
                end
            end
            K_CLAIM: begin
                if (int'(r.sid) >= TABLE_SIZE) begin
                    res.status = STS_BAD_ID;
                end else if (tag_mem[r.sid] != r.magic) begin
                    res.status = STS_MISMATCH;
                end else begin
                    res.out_data  = data_mem[r.sid];
                    res.out_reply = reply_mem[r.sid];
                    res.out_start = start_mem[r.sid];
                    tag_mem[r.sid] = '0;
                end
            end
            K_RELEASE: begin
                if (int'(r.sid) >= TABLE_SIZE) begin
                    res.status = STS_BAD_ID;
                end else if (!busy[r.sid]) begin
                    res.status = STS_NOT_IN_USE;
                end else begin
                    busy[r.sid] = 1'b0;
                    free_push(int'(r.sid));
                end
            end
            default: begin
                res.status = STS_BAD_ID;
            end
        endcase
        return res;
    endfunction

    always @(posedge i_clk) begin : watch
        t_res want;
        if (!i_rst_n) begin
            clear_state();
            pending_results.delete();
            o_pending <= 0;
        end else begin
            if (i_pop && !i_empty) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch($sformatf("result beat with nothing expected, sid %0d",
                                            i_res.out_sid));
                end else begin
                    want = pending_results[0];
                    pending_results.delete(0);
                    if (i_res.status !== want.status)
                        flag_mismatch($sformatf("status got %0d expected %0d (sid %0d)",
                                                i_res.status, want.status, want.out_sid));
                    if (i_res.out_sid !== want.out_sid)
                        flag_mismatch($sformatf("out_sid got %0d expected %0d",
                                                i_res.out_sid, want.out_sid));
                    if (i_res.out_data !== want.out_data)
                        flag_mismatch($sformatf("out_data got %h expected %h (sid %0d)",
                                                i_res.out_data, want.out_data, want.out_sid));
                    if (i_res.out_reply !== want.out_reply)
                        flag_mismatch($sformatf("out_reply got %h expected %h (sid %0d)",
                                                i_res.out_reply, want.out_reply, want.out_sid));
                    if (i_res.out_start !== want.out_start)
                        flag_mismatch($sformatf("out_start got %h expected %h (sid %0d)",
                                                i_res.out_start, want.out_start, want.out_sid));
                end
            end
            if (i_push && !i_full)
                pending_results.insert(pending_results.size(), session_outcome(i_req));
            o_pending <= pending_results.size();
        end
    end

endmodule

// File: test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: session id allocator with tag check
// Drives open, claim and release beats in bursts against a stalling result
// side, fills the table to exhaustion once, and takes the verdict from the
// checker that sits beside the block.
// ----------------------------------------------------------------------------
module testbench;
    import sia_pkg::*;

    localparam int TABLE_SIZE  = 1024;
    localparam int BATCH       = 10;
    // limit sits well above the reset sweep of all TABLE_SIZE entries, with full high
    localparam int STALL_LIMIT = 6000;
    localparam int TAIL_CYCLES = 20;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    logic pop     = 1'b0;
    logic full;
    logic empty;
    t_req i_req   = '0;
    t_res o_res;

    int errors;
    int pending;

    // sessions known open on the stimulus side, with the magic they hold now
    typedef struct {
        logic [SID_W-1:0] sid;
        logic [W32-1:0]   magic;
    } t_live;

    t_live live [$];
    t_req  issued [$];
    bit    exhausted   = 1'b0;
    int    burst_left  = 0;
    int    stall_count = 0;
    int    pop_mode    = 0;
    int    mode_left   = 0;

    always #5 i_clk = ~i_clk;

    session_id_allocator_with_tag_check #(
        .TABLE_SIZE (TABLE_SIZE),
        .BATCH      (BATCH)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_req   (i_req),
        .pop     (pop),
        .empty   (empty),
        .o_res   (o_res)
    );

    session_id_checker #(
        .TABLE_SIZE (TABLE_SIZE),
        .BATCH      (BATCH)
    ) u_check (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_push    (push),
        .i_full    (full),
        .i_req     (i_req),
        .i_pop     (pop),
        .i_empty   (empty),
        .i_res     (o_res),
        .o_errors  (errors),
        .o_pending (pending)
    );

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------

    function automatic int new_burst();
        // mostly short bursts; now and then a long stretch with no gaps
        if ($urandom_range(0, 3) == 0)
            return $urandom_range(80, 250);
        return $urandom_range(1, 24);
    endfunction

    function automatic t_req make_req(input t_kind k, input logic [SID_W-1:0] sid,
                                      input logic [W32-1:0] magic,
                                      input logic [W32-1:0] data,
                                      input logic [W32-1:0] reply,
                                      input logic [W32-1:0] now);
        t_req r;
        r.kind         = k;
        r.sid          = sid;
        r.magic        = magic;
        r.data_handle  = data;
        r.reply_handle = reply;
        r.now_seconds  = now;
        return r;
    endfunction

    function automatic t_req random_open();
        t_req r;
        r = make_req(K_OPEN, SID_W'($urandom), $urandom, $urandom, $urandom, $urandom);
        // a zero tag makes a later claim look like one on a fresh entry
        if ($urandom_range(0, 15) == 0)
            r.magic = '0;
        return r;
    endfunction

    // claim a live session, mostly with its current tag; zero the tag on a hit
    function automatic t_req pick_claim();
        t_req r;
        int   idx;
        r = random_open();
        r.kind = K_CLAIM;
        if (live.size() > 0 && $urandom_range(0, 4) != 0) begin
            idx   = $urandom_range(0, live.size() - 1);
            r.sid = live[idx].sid;
            if ($urandom_range(0, 6) != 0) begin
                r.magic = live[idx].magic;
                live[idx].magic = '0;
            end else begin
                r.magic = live[idx].magic ^ (32'h1 << $urandom_range(0, 31));
            end
        end else if ($urandom_range(0, 3) == 0) begin
            r.magic = '0;
        end
        return r;
    endfunction

    // release a live session, or now and then a random id
    function automatic t_req pick_release();
        t_req r;
        int   idx;
        r = random_open();
        r.kind = K_RELEASE;
        if (live.size() > 0 && $urandom_range(0, 6) != 0) begin
            idx   = $urandom_range(0, live.size() - 1);
            r.sid = live[idx].sid;
            live.delete(idx);
        end
        return r;
    endfunction

    // present one beat, hold it until taken, then maybe close the burst
    task automatic send(input t_req r);
        i_req <= r;
        push  <= 1'b1;
        @(posedge i_clk);
        while (full)
            @(posedge i_clk);
        issued.insert(issued.size(), r);
        burst_left--;
        if (burst_left <= 0) begin
            push <= 1'b0;
            repeat ($urandom_range(1, 12))
                @(posedge i_clk);
            burst_left = new_burst();
        end
    endtask

    // drop push and hold off until every expected result has been taken
    task automatic drain();
        push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0)
            @(posedge i_clk);
        burst_left = new_burst();
    endtask

    task automatic run_mix(input int count, input int open_pct, input int claim_pct);
        int   roll;
        t_req r;
        for (int i = 0; i < count; i++) begin
            roll = $urandom_range(0, 99);
            if (roll < 4)
                r = make_req(K_UNKNOWN, SID_W'($urandom), $urandom, $urandom,
                             $urandom, $urandom);
            else if (roll < 4 + open_pct)
                r = random_open();
            else if (roll < 4 + open_pct + claim_pct)
                r = pick_claim();
            else
                r = pick_release();
            send(r);
        end
    endtask

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main
        int n;
        repeat (11)
            @(posedge i_clk);
        i_rst_n    <= 1'b1;
        burst_left = new_burst();

        // Directed part. Claim a never opened entry: its tag is zero, so a
        // zero magic hits and a nonzero one misses.
        send(make_req(K_CLAIM, 10'h3FF, 32'h0, 32'h0, 32'h0, 32'h0));
        send(make_req(K_CLAIM, 10'd5, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
        // release of an id that is free, and the unknown kind at both ends
        send(make_req(K_RELEASE, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0));
        send(make_req(K_UNKNOWN, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send(make_req(K_UNKNOWN, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0));
        // first open pulls in the first batch; fields at both extremes
        send(make_req(K_OPEN, 10'h3FF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF));
        send(make_req(K_OPEN, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0));
        send(make_req(K_OPEN, 10'h155, 32'h1234_5678, 32'hA5A5_A5A5,
                      32'h5A5A_5A5A, 32'h0001_0000));
        // hit, then the same tag again misses because the hit zeroed it
        send(make_req(K_CLAIM, 10'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
        send(make_req(K_CLAIM, 10'd0, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0));
        send(make_req(K_CLAIM, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0));
        // release twice: the second finds the id free
        send(make_req(K_RELEASE, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0));
        send(make_req(K_RELEASE, 10'd0, 32'h0, 32'h0, 32'h0, 32'h0));
        send(make_req(K_CLAIM, 10'd2, 32'h1234_5679, 32'h0, 32'h0, 32'h0));
        send(make_req(K_RELEASE, 10'd1, 32'h0, 32'h0, 32'h0, 32'h0));
        send(make_req(K_RELEASE, 10'd2, 32'h0, 32'h0, 32'h0, 32'h0));
        // run through the rest of the batch and into the released ids
        for (int i = 0; i < 9; i++)
            send(make_req(K_OPEN, SID_W'(i), 32'h1 << i, ~(32'h1 << i),
                          32'(i * 3), 32'hFFFF_FFFF - 32'(i)));
        drain();
        live.delete();

        // Random part: a general mix, then a pause until all results are in.
        run_mix(80, 40, 30);
        drain();

        // Fill the table until an open comes back with no free id.
        n = 0;
        while (!exhausted && n < 1100) begin
            send(random_open());
            n++;
        end
        repeat (3)
            send(random_open());

        // Release heavy mix to churn the full free list.
        run_mix(100, 28, 30);

        drain();
        repeat (TAIL_CYCLES)
            @(posedge i_clk);
        if (errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: learn which opens succeeded so later beats can target them
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : observe
        t_req  r;
        t_live lv;
        if (i_rst_n && pop && !empty && issued.size() > 0) begin
            r = issued[0];
            issued.delete(0);
            if (r.kind == K_OPEN) begin
                if (o_res.status == STS_OK) begin
                    lv.sid   = o_res.out_sid;
                    lv.magic = r.magic;
                    live.insert(live.size(), lv);
                end else if (o_res.status == STS_NO_FREE) begin
                    exhausted = 1'b1;
                end
            end
        end
    end

    // Receiver stall pattern: switch among steady pop, coin flips, sparse
    // pops and long stalls, each held for a random stretch.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (mode_left <= 0) begin
                pop_mode  = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            case (pop_mode)
                0: pop <= 1'b1;
                1: pop <= 1'($urandom_range(0, 1));
                2: pop <= ($urandom_range(0, 3) == 0);
                default: pop <= ((mode_left % 40) < 10);
            endcase
        end
    end

    // Watchdog: end the run if no beat moves on either side for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty)) begin
            stall_count <= 0;
        end else begin
            stall_count <= stall_count + 1;
            if (stall_count >= STALL_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

endmodule

// File: session_id_allocator_with_tag_check.f
rtl/core/sia_pkg.sv
rtl/core/sia_q.sv
rtl/core/sia_front.sv
rtl/core/sia_back.sv
rtl/core/session_id_allocator_with_tag_check.sv
test/session_id_checker.sv
test/testbench.sv
